>>> design/wla_pkg.sv
// shared widths, register indexes and reset values of the load average block
package wla_pkg;

    localparam int WORD_W  = 32;
    localparam int TASK_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_WIN = 3;
    localparam int SEL_W   = 2;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 128;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_SHORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_MID      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LONG     = 2'd3;

    localparam logic [WORD_W-1:0] RST_MIN_INTERVAL = 32'd5000;
    localparam logic [WORD_W-1:0] RST_WIN_SHORT    = 32'd60000;
    localparam logic [WORD_W-1:0] RST_WIN_MID      = 32'd300000;
    localparam logic [WORD_W-1:0] RST_WIN_LONG     = 32'd900000;

    localparam logic [SEL_W-1:0] SEL_SHORT = 2'd0;
    localparam logic [SEL_W-1:0] SEL_MID   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_LONG  = 2'd2;

endpackage

>>> design/wla_mac.sv
// bit-serial multiply-accumulate: delta*target + rest*load, one multiplier bit per cycle
module wla_mac
    import wla_pkg::*;
#(
    parameter int TGT_W = 28,
    parameter int ACC_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_delta,
    input  logic [WORD_W-1:0] i_rest,
    input  logic [TGT_W-1:0]  i_target,
    input  logic [WORD_W-1:0] i_load,
    output logic [ACC_W-1:0]  o_acc,
    output logic              o_done
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] r_dsh;
    logic [WORD_W-1:0] r_wsh;
    logic [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ACC_W-1:0]  n_acc;

    // msb first: double the partial sum, then add the selected terms
    always_comb begin
        n_acc = {r_acc[ACC_W-2:0], 1'b0};
        if (r_dsh[WORD_W-1]) begin
            n_acc = n_acc + ACC_W'(i_target);
        end
        if (r_wsh[WORD_W-1]) begin
            n_acc = n_acc + ACC_W'(i_load);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_dsh  <= '0;
            r_wsh  <= '0;
            r_acc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dsh  <= i_delta;
                r_wsh  <= i_rest;
                r_acc  <= '0;
                r_cnt  <= CNT_W'(WORD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_dsh <= {r_dsh[WORD_W-2:0], 1'b0};
                r_wsh <= {r_wsh[WORD_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

>>> design/wla_div.sv
// restoring divider, one quotient bit per cycle, numerator and quotient share one shift register
module wla_div
    import wla_pkg::*;
#(
    parameter int Q_W   = 32,
    parameter int ACC_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_num,
    input  logic [WORD_W-1:0] i_den,
    output logic [Q_W-1:0]    o_quot,
    output logic              o_done
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [WORD_W-1:0] r_rem;
    logic [Q_W-1:0]    r_qn;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              q_bit;

    assign trial = {r_rem, r_qn[Q_W-1]};
    assign diff  = trial - {1'b0, i_den};
    assign q_bit = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_qn   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // upper part is already below the divisor since the quotient fits Q_W bits
                r_rem  <= i_num[ACC_W-1:Q_W];
                r_qn   <= i_num[Q_W-1:0];
                r_cnt  <= CNT_W'(Q_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= q_bit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                r_qn  <= {r_qn[Q_W-2:0], q_bit};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_qn;
    assign o_done = r_done;

endmodule

>>> design/windowed_load_average.sv
// top level: three windowed fixed-point load averages with a shared serial datapath
// One request word in gives one result word out. A request whose elapsed ticks stay
// below the minimum interval goes straight to the result. A recomputing request walks
// the short, middle and long windows in turn through one bit-serial multiply-accumulate
// and one restoring divider. A window already spanned by the elapsed ticks skips both
// and takes the target directly. A new request is taken as soon as the previous result
// sits in the output register.
module windowed_load_average
    import wla_pkg::*;
#(
    parameter int FRAC_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WORD_W-1:0]     i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // now_ticks, running_tasks, blocked_tasks
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // load_short, load_mid, load_long, request_count
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // recomputed
    output logic                  o_m_tuser
);

    localparam int TGT_W = TASK_W + 1 + FRAC_BITS;
    localparam int MAG_W = (TGT_W > WORD_W) ? TGT_W : WORD_W;
    localparam int ACC_W = MAG_W + WORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_MAC,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_min;
    logic [WORD_W-1:0] r_win [NUM_WIN];
    logic [WORD_W-1:0] r_load [NUM_WIN];
    logic [WORD_W-1:0] r_last;
    logic [WORD_W-1:0] r_count;
    logic [WORD_W-1:0] r_now;
    logic [WORD_W-1:0] r_delta;
    logic [TGT_W-1:0]  r_target;
    logic              r_recomp;
    logic [SEL_W-1:0]  r_sel;
    logic              r_mac_start;
    logic              r_div_start;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic              r_out_user;

    logic [WORD_W-1:0] in_now;
    logic [TASK_W:0]   in_tasks;
    logic [WORD_W-1:0] in_delta;
    logic [WORD_W-1:0] cur_win;
    logic [WORD_W-1:0] cur_rest;
    logic [ACC_W-1:0]  mac_acc;
    logic              mac_done;
    logic [MAG_W-1:0]  div_quot;
    logic              div_done;
    logic              accept;

    function automatic logic [WORD_W-1:0] sat_word(input logic [MAG_W-1:0] v);
        if (v > MAG_W'({WORD_W{1'b1}})) begin
            return {WORD_W{1'b1}};
        end
        return v[WORD_W-1:0];
    endfunction

    assign in_now   = i_s_tdata[WORD_W-1:0];
    assign in_tasks = {1'b0, i_s_tdata[WORD_W +: TASK_W]}
                    + {1'b0, i_s_tdata[WORD_W+TASK_W +: TASK_W]};
    assign in_delta = in_now - r_last;
    assign cur_win  = r_win[r_sel];
    assign cur_rest = cur_win - r_delta;
    assign accept   = i_s_tvalid && (r_state == S_IDLE);

    wla_mac #(
        .TGT_W (TGT_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mac_start),
        .i_delta  (r_delta),
        .i_rest   (cur_rest),
        .i_target (r_target),
        .i_load   (r_load[r_sel]),
        .o_acc    (mac_acc),
        .o_done   (mac_done)
    );

    wla_div #(
        .Q_W   (MAG_W),
        .ACC_W (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (mac_acc),
        .i_den   (cur_win),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= RST_MIN_INTERVAL;
            r_win[SEL_SHORT] <= RST_WIN_SHORT;
            r_win[SEL_MID]   <= RST_WIN_MID;
            r_win[SEL_LONG]  <= RST_WIN_LONG;
            r_load[SEL_SHORT] <= '0;
            r_load[SEL_MID]   <= '0;
            r_load[SEL_LONG]  <= '0;
            r_last      <= '0;
            r_count     <= '0;
            r_now       <= '0;
            r_delta     <= '0;
            r_target    <= '0;
            r_recomp    <= 1'b0;
            r_sel       <= SEL_SHORT;
            r_mac_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_out_user  <= 1'b0;
        end else begin
            r_mac_start <= 1'b0;
            r_div_start <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_INTERVAL: r_min            <= i_cfg_data;
                    REG_WIN_SHORT:    r_win[SEL_SHORT] <= i_cfg_data;
                    REG_WIN_MID:      r_win[SEL_MID]   <= i_cfg_data;
                    REG_WIN_LONG:     r_win[SEL_LONG]  <= i_cfg_data;
                    default: ;
                endcase
            end

            // the done state refills the output register itself
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now    <= in_now;
                        r_delta  <= in_delta;
                        r_target <= TGT_W'(in_tasks) << FRAC_BITS;
                        r_recomp <= (in_delta >= r_min);
                        r_count  <= r_count + WORD_W'(1);
                        r_sel    <= SEL_SHORT;
                        r_state  <= (in_delta >= r_min) ? S_PICK : S_DONE;
                    end
                end
                S_PICK: begin
                    if (r_delta >= cur_win) begin
                        // window fully elapsed: jump straight to the target
                        r_load[r_sel] <= sat_word(MAG_W'(r_target));
                        if (r_sel == SEL_LONG) begin
                            r_last  <= r_now;
                            r_state <= S_DONE;
                        end else begin
                            r_sel <= r_sel + SEL_W'(1);
                        end
                    end else begin
                        r_mac_start <= 1'b1;
                        r_state     <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_load[r_sel] <= sat_word(div_quot);
                        if (r_sel == SEL_LONG) begin
                            r_last  <= r_now;
                            r_state <= S_DONE;
                        end else begin
                            r_sel   <= r_sel + SEL_W'(1);
                            r_state <= S_PICK;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_count, r_load[SEL_LONG],
                                        r_load[SEL_MID], r_load[SEL_SHORT]};
                        r_out_user  <= r_recomp;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

>>> tb/load_average_checker.sv
// checker for the load average block: snoops the register port, predicts and compares results
module load_average_checker
    import wla_pkg::*;
#(
    parameter int FRAC_BITS = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WORD_W-1:0]     i_cfg_data,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // now_ticks, running_tasks, blocked_tasks
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // load_short, load_mid, load_long, request_count
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // recomputed
    input  logic                  i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_recompute_count
);

    typedef struct packed {
        logic [NUM_WIN-1:0][WORD_W-1:0] loads;
        logic                           recomputed;
        logic [WORD_W-1:0]              count;
    } t_load_result;

    logic [WORD_W-1:0] min_interval;
    logic [WORD_W-1:0] window_len [NUM_WIN];
    logic [WORD_W-1:0] avg_value  [NUM_WIN];
    logic [WORD_W-1:0] last_tick;
    logic [WORD_W-1:0] request_total;
    t_load_result      expected_loads [$];
    int                mismatches    = 0;
    int                recomputes    = 0;
    int                pending_words = 0;
    string             win_label [NUM_WIN] = '{"load_short", "load_mid", "load_long"};

    assign o_fail_count      = mismatches;
    assign o_pending         = pending_words;
    assign o_recompute_count = recomputes;

    task automatic report_mismatch(input string msg);
        $display("%0t  %s", $time, msg);
        mismatches++;
    endtask

    // one window step: exact quotient over the full-width numerator, clipped to 32 bits
    function automatic logic [WORD_W-1:0] blend_average(
        input logic [WORD_W-1:0] prev,
        input logic [WORD_W-1:0] win,
        input logic [WORD_W-1:0] elapsed,
        input logic [63:0]       target
    );
        logic [WORD_W-1:0] rest;
        logic [127:0]      sum;
        logic [127:0]      quot;
        if (elapsed >= win) begin
            return (target > 64'hFFFF_FFFF) ? '1 : target[WORD_W-1:0];
        end
        rest = win - elapsed;
        sum  = 128'(elapsed) * 128'(target) + 128'(rest) * 128'(prev);
        quot = sum / 128'(win);
        return (quot > 128'hFFFF_FFFF) ? '1 : quot[WORD_W-1:0];
    endfunction

    function automatic t_load_result predict_request(input logic [IN_DATA_W-1:0] word);
        t_load_result      res;
        logic [WORD_W-1:0] now_tick;
        logic [WORD_W-1:0] elapsed;
        logic [63:0]       target;
        now_tick = word[WORD_W-1:0];
        target   = (64'(word[WORD_W +: TASK_W]) + 64'(word[WORD_W+TASK_W +: TASK_W]))
                   << FRAC_BITS;
        elapsed  = now_tick - last_tick;
        res.recomputed = (elapsed >= min_interval);
        if (res.recomputed) begin
            for (int w = 0; w < NUM_WIN; w++) begin
                avg_value[w] = blend_average(avg_value[w], window_len[w], elapsed, target);
            end
            last_tick = now_tick;
        end
        request_total = request_total + 1'b1;
        for (int w = 0; w < NUM_WIN; w++) begin
            res.loads[w] = avg_value[w];
        end
        res.count = request_total;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_load_result got;
        t_load_result want;
        if (!i_rst_n) begin
            min_interval          = RST_MIN_INTERVAL;
            window_len[SEL_SHORT] = RST_WIN_SHORT;
            window_len[SEL_MID]   = RST_WIN_MID;
            window_len[SEL_LONG]  = RST_WIN_LONG;
            avg_value             = '{default: '0};
            last_tick             = '0;
            request_total         = '0;
            expected_loads.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MIN_INTERVAL: min_interval = i_cfg_data;
                    REG_WIN_SHORT:    window_len[SEL_SHORT] = i_cfg_data;
                    REG_WIN_MID:      window_len[SEL_MID] = i_cfg_data;
                    REG_WIN_LONG:     window_len[SEL_LONG] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_loads.push_back(predict_request(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                for (int w = 0; w < NUM_WIN; w++) begin
                    got.loads[w] = i_m_tdata[w*WORD_W +: WORD_W];
                end
                got.recomputed = i_m_tuser;
                got.count      = i_m_tdata[NUM_WIN*WORD_W +: WORD_W];
                if (expected_loads.size() == 0) begin
                    report_mismatch($sformatf("result word with no request outstanding, count %h",
                                              got.count));
                end else begin
                    want = expected_loads.pop_front();
                    if (want.recomputed) begin
                        recomputes++;
                    end
                    for (int w = 0; w < NUM_WIN; w++) begin
                        if (got.loads[w] !== want.loads[w]) begin
                            report_mismatch($sformatf("%s wrong on request %0d: got %h, want %h",
                                win_label[w], want.count, got.loads[w], want.loads[w]));
                        end
                    end
                    if (got.recomputed !== want.recomputed) begin
                        report_mismatch($sformatf("recomputed wrong on request %0d: got %b, want %b",
                            want.count, got.recomputed, want.recomputed));
                    end
                    if (got.count !== want.count) begin
                        report_mismatch($sformatf("request_count wrong: got %h, want %h",
                            got.count, want.count));
                    end
                end
            end
        end
        pending_words <= expected_loads.size();
    end

endmodule

>>> tb/windowed_load_average_tb.sv
// testbench top for the windowed load average block: stimulus, register settings and verdict
module windowed_load_average_tb;
    import wla_pkg::*;

    localparam int FRAC_BITS   = 11;
    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int TAIL_CYCLES = 256;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [WORD_W-1:0]     i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;

    int fail_count;
    int pending;
    int recompute_count;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int words_sent         = 0;
    int settings_count     = 0;

    // mirror of the registers and of the last recompute tick, used only to aim the deltas
    logic [WORD_W-1:0] cur_min;
    logic [WORD_W-1:0] cur_win [NUM_WIN];
    logic [WORD_W-1:0] anchor_tick;

    windowed_load_average #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    load_average_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) avg_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tuser         (o_m_tuser),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_recompute_count (recompute_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic write_settings(
        input logic [WORD_W-1:0] min_iv,
        input logic [WORD_W-1:0] win_s,
        input logic [WORD_W-1:0] win_m,
        input logic [WORD_W-1:0] win_l
    );
        drain_results();
        write_reg(REG_MIN_INTERVAL, min_iv);
        write_reg(REG_WIN_SHORT, win_s);
        write_reg(REG_WIN_MID, win_m);
        write_reg(REG_WIN_LONG, win_l);
        i_cfg_we <= 1'b0;
        cur_min            = min_iv;
        cur_win[SEL_SHORT] = win_s;
        cur_win[SEL_MID]   = win_m;
        cur_win[SEL_LONG]  = win_l;
        settings_count++;
    endtask

    task automatic send_request(
        input logic [WORD_W-1:0] now_tick,
        input logic [TASK_W-1:0] running,
        input logic [TASK_W-1:0] blocked
    );
        logic [WORD_W-1:0] elapsed;
        i_s_tdata  <= {blocked, running, now_tick};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
        elapsed = now_tick - anchor_tick;
        if (elapsed >= cur_min) begin
            anchor_tick = now_tick;
        end
    endtask

    task automatic send_random_request();
        logic [WORD_W-1:0] span;
        logic [WORD_W-1:0] delta;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] now_tick;
        logic [TASK_W-1:0] running;
        logic [TASK_W-1:0] blocked;
        span = cur_win[$urandom_range(NUM_WIN-1)];
        case ($urandom_range(7))
            0: delta = $urandom;
            1: delta = (cur_min == 0) ? '0 : $urandom_range(cur_min - 1);
            2: delta = cur_min;
            3: delta = span;
            4: delta = span - 1;
            5: delta = span + 1;
            default: begin
                hi    = (span < cur_min) ? cur_min : span;
                delta = $urandom_range(hi, cur_min);
            end
        endcase
        now_tick = anchor_tick + delta;
        case ($urandom_range(3))
            0: begin
                running = TASK_W'($urandom_range(8));
                blocked = TASK_W'($urandom_range(8));
            end
            1: begin
                running = $urandom_range(1) ? '1 : '0;
                blocked = $urandom_range(1) ? '1 : '0;
            end
            default: {blocked, running} = $urandom;
        endcase
        send_request(now_tick, running, blocked);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_MIN_INTERVAL;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_m_tready <= 1'b0;
        cur_min            = RST_MIN_INTERVAL;
        cur_win[SEL_SHORT] = RST_WIN_SHORT;
        cur_win[SEL_MID]   = RST_WIN_MID;
        cur_win[SEL_LONG]  = RST_WIN_LONG;
        anchor_tick        = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: below, at and past the minimum interval and the windows
        send_request(32'd0, 16'd0, 16'd0);
        send_request(32'd4999, '1, '1);
        send_request(32'd5000, '1, '1);
        send_request(anchor_tick + RST_WIN_SHORT, 16'd0, 16'd0);
        send_request(anchor_tick + 1, 16'd1, 16'd0);
        send_request(32'hFFFF_FFFF, 16'h8000, 16'h0001);
        // tick count wrapping through zero
        send_request(32'h0000_1000, 16'h00FF, 16'hFF00);
        send_request(anchor_tick + RST_MIN_INTERVAL, 16'h5555, 16'hAAAA);
        send_request(anchor_tick + RST_WIN_MID - 1, 16'd3, 16'd5);
        send_request(anchor_tick + RST_WIN_LONG + 7, 16'hAAAA, 16'h5555);

        // zero windows and no minimum interval: every word recomputes straight to the target
        write_settings('0, '0, '0, '0);
        send_request(anchor_tick, 16'd2, 16'd1);
        send_request(anchor_tick + 3, 16'hFFFF, 16'd0);
        send_request(32'h8000_0000, 16'd0, 16'hFFFF);

        // widest minimum interval: only the full-range delta recomputes
        write_settings('1, 32'd1, '1, 32'd7);
        send_request(anchor_tick + 32'hFFFF_FFFE, 16'd9, 16'd9);
        send_request(anchor_tick - 1, 16'd9, 16'd9);
        send_request(anchor_tick + 2, 16'd1, 16'd1);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: write_settings(RST_MIN_INTERVAL, RST_WIN_SHORT, RST_WIN_MID, RST_WIN_LONG);
                1: write_settings('0, 32'd1, 32'd2, 32'd3);
                2: write_settings(32'd1, '1, '1, '1);
                3: write_settings($urandom_range(1000), $urandom_range(100000, 1),
                                  $urandom_range(100000, 1), $urandom_range(100000, 1));
                4: write_settings('1, $urandom, $urandom, $urandom);
                5: write_settings($urandom, $urandom, $urandom, $urandom);
                6: write_settings($urandom_range(50), '0, '0, '0);
                default: write_settings($urandom_range(10), $urandom_range(5000, 1),
                                        $urandom_range(5000, 1), $urandom_range(5000, 1));
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(199) == 0) begin
                    drain_results();
                end
                while ($urandom_range(99) < sender_idle_pct) begin
                    i_s_tvalid <= 1'b0;
                    @(posedge i_clk);
                end
                send_random_request();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d update requests under %0d register settings, %0d of them recomputing",
                 words_sent, settings_count, recompute_count);
        $display("idle phases covered: none, sender only, receiver only, both");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
design/wla_pkg.sv
design/wla_mac.sv
design/wla_div.sv
design/windowed_load_average.sv
tb/load_average_checker.sv
tb/windowed_load_average_tb.sv
